/* hdl/hsl_pkg.sv */
package hsl_pkg;

    localparam int POS_W      = 32;
    localparam int EXT_W      = (POS_W > 32) ? POS_W : 32;
    localparam int COUNT_W    = 16;
    localparam int SPEED_W    = 7;
    localparam int DRIVE_W    = 8;
    localparam int OUT_POS_W  = 32;
    localparam int THR_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(100);

    localparam logic [SPEED_W-1:0]      RST_CRUISE_SPEED = SPEED_W'(100);
    localparam logic [SPEED_W-1:0]      RST_CREEP_SPEED  = SPEED_W'(30);
    localparam logic signed [THR_W-1:0] RST_SLOW_BELOW   = THR_W'(196608);
    localparam logic signed [THR_W-1:0] RST_SLOW_ABOVE   = THR_W'(1769472);
    localparam logic signed [THR_W-1:0] RST_FAST_FROM    = THR_W'(393216);
    localparam logic signed [THR_W-1:0] RST_FAST_TO      = THR_W'(1572864);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRUISE_SPEED,
        CFG_CREEP_SPEED,
        CFG_SLOW_BELOW,
        CFG_SLOW_ABOVE,
        CFG_FAST_FROM,
        CFG_FAST_TO
    } t_cfg_idx;

    typedef struct packed {
        logic [SPEED_W-1:0]      cruise_speed;
        logic [SPEED_W-1:0]      creep_speed;
        logic signed [THR_W-1:0] slow_below;
        logic signed [THR_W-1:0] slow_above;
        logic signed [THR_W-1:0] fast_from;
        logic signed [THR_W-1:0] fast_to;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [COUNT_W-1:0]      last_count;
        logic                    started;
        logic                    slow_flag;
    } t_state;

    typedef struct packed {
        logic signed [COUNT_W-1:0] encoder_count;
        logic                      home_switch;
        logic                      far_switch;
        logic                      forward_button;
        logic                      reverse_button;
    } t_sample;

    typedef struct packed {
        logic signed [DRIVE_W-1:0]   drive_command;
        logic                        slow_zone;
        logic signed [OUT_POS_W-1:0] axis_position;
    } t_result;

endpackage

/* hdl/hsl_in_if.sv */
interface hsl_in_if
    import hsl_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COUNT_W-1:0] encoder_count;
    logic                      home_switch;
    logic                      far_switch;
    logic                      forward_button;
    logic                      reverse_button;

    modport source (
        output valid, encoder_count, home_switch, far_switch,
               forward_button, reverse_button,
        input  ready
    );
    modport sink (
        input  valid, encoder_count, home_switch, far_switch,
               forward_button, reverse_button,
        output ready
    );
endinterface

/* hdl/hsl_out_if.sv */
interface hsl_out_if
    import hsl_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [DRIVE_W-1:0]   drive_command;
    logic                        slow_zone;
    logic signed [OUT_POS_W-1:0] axis_position;

    modport source (
        output valid, drive_command, slow_zone, axis_position,
        input  ready
    );
    modport sink (
        input  valid, drive_command, slow_zone, axis_position,
        output ready
    );
endinterface

/* hdl/hsl_step.sv */
module hsl_step
    import hsl_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_cur,
    input  t_sample i_smp,
    output t_state  o_nxt,
    output t_result o_res
);

    localparam logic signed [POS_W:0] POS_MAX_X = {2'b00, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W:0] POS_MIN_X = {2'b11, {(POS_W-1){1'b0}}};

    logic signed [COUNT_W-1:0] diff;
    logic signed [POS_W:0]     sum;
    logic signed [POS_W-1:0]   tracked;
    logic signed [POS_W-1:0]   pos;
    logic signed [EXT_W-1:0]   pos_x;
    logic                      set_slow;
    logic                      clr_slow;
    logic                      slow;
    logic [SPEED_W-1:0]        raw_speed;
    logic [SPEED_W-1:0]        speed;
    logic signed [DRIVE_W-1:0] spd_s;
    logic signed [DRIVE_W-1:0] drive;

    // wrap difference, then subtract with saturation at the position limits
    assign diff = i_smp.encoder_count - signed'(i_cur.last_count);
    assign sum  = (POS_W+1)'(i_cur.position) - (POS_W+1)'(diff);

    always_comb begin
        if (sum[POS_W] != sum[POS_W-1]) begin
            tracked = sum[POS_W] ? POS_MIN_X[POS_W-1:0] : POS_MAX_X[POS_W-1:0];
        end else begin
            tracked = sum[POS_W-1:0];
        end
    end

    always_comb begin
        if (i_smp.home_switch) begin
            pos = '0;
        end else if (i_cur.started) begin
            pos = tracked;
        end else begin
            pos = i_cur.position;
        end
    end

    // hysteresis on the new position
    assign pos_x    = EXT_W'(pos);
    assign set_slow = (pos_x <= EXT_W'(i_cfg.slow_below)) ||
                      (pos_x >= EXT_W'(i_cfg.slow_above));
    assign clr_slow = (pos_x >= EXT_W'(i_cfg.fast_from)) &&
                      (pos_x <= EXT_W'(i_cfg.fast_to));
    assign slow     = set_slow ? 1'b1 : (clr_slow ? 1'b0 : i_cur.slow_flag);

    assign raw_speed = slow ? i_cfg.creep_speed : i_cfg.cruise_speed;
    assign speed     = (raw_speed > SPEED_MAX) ? SPEED_MAX : raw_speed;
    assign spd_s     = signed'(DRIVE_W'(speed));

    always_comb begin
        if (i_smp.home_switch) begin
            drive = i_smp.reverse_button ? -spd_s : '0;
        end else if (i_smp.far_switch) begin
            drive = i_smp.forward_button ? spd_s : '0;
        end else if (i_smp.forward_button) begin
            drive = spd_s;
        end else if (i_smp.reverse_button) begin
            drive = -spd_s;
        end else begin
            drive = '0;
        end
    end

    assign o_nxt.position   = pos;
    assign o_nxt.last_count = i_smp.encoder_count;
    assign o_nxt.started    = 1'b1;
    assign o_nxt.slow_flag  = slow;

    assign o_res.drive_command = drive;
    assign o_res.slow_zone     = slow;
    assign o_res.axis_position = OUT_POS_W'(pos);

endmodule

/* hdl/homed_axis_speed_limiter.sv */
// Homed axis speed limiter. Each input item is one sensor tick (encoder count,
// end switches, buttons); each one yields exactly one result item with the
// gated drive command, the slow-zone flag and the tracked axis position.
// Items pass an input register and then a result register; a result is
// presented once its item has moved on into the result register, and one
// item per cycle is sustained while the result is not stalled. A stalled
// result holds the result register, the input register still takes one
// more item.
// Configuration is a plain write port (index 0..5: cruise_speed, creep_speed,
// slow_below, slow_above, fast_from, fast_to); write it only while idle.
// Other indexes are ignored.
module homed_axis_speed_limiter
    import hsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hsl_in_if.sink                i_item,
    hsl_out_if.source             o_res
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_sample r_smp;
    t_result r_res;
    t_result n_res;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    out_free;
    logic    advance;
    logic    take;

    // advance the input stage into the result stage whenever the result is free
    assign out_free = !r_out_valid || o_res.ready;
    assign advance  = r_in_valid && out_free;
    assign take     = i_item.valid && i_item.ready;

    assign i_item.ready = !r_in_valid || out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise_speed <= RST_CRUISE_SPEED;
            r_cfg.creep_speed  <= RST_CREEP_SPEED;
            r_cfg.slow_below   <= RST_SLOW_BELOW;
            r_cfg.slow_above   <= RST_SLOW_ABOVE;
            r_cfg.fast_from    <= RST_FAST_FROM;
            r_cfg.fast_to      <= RST_FAST_TO;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CRUISE_SPEED: r_cfg.cruise_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_CREEP_SPEED:  r_cfg.creep_speed  <= i_cfg_data[SPEED_W-1:0];
                CFG_SLOW_BELOW:   r_cfg.slow_below   <= signed'(i_cfg_data[THR_W-1:0]);
                CFG_SLOW_ABOVE:   r_cfg.slow_above   <= signed'(i_cfg_data[THR_W-1:0]);
                CFG_FAST_FROM:    r_cfg.fast_from    <= signed'(i_cfg_data[THR_W-1:0]);
                CFG_FAST_TO:      r_cfg.fast_to      <= signed'(i_cfg_data[THR_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    hsl_step u_step (
        .i_cfg (r_cfg),
        .i_cur (r_state),
        .i_smp (r_smp),
        .o_nxt (n_state),
        .o_res (n_res)
    );

    // control: valid flags and axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold the sample until it moves on, hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_smp.encoder_count  <= i_item.encoder_count;
            r_smp.home_switch    <= i_item.home_switch;
            r_smp.far_switch     <= i_item.far_switch;
            r_smp.forward_button <= i_item.forward_button;
            r_smp.reverse_button <= i_item.reverse_button;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.drive_command = r_res.drive_command;
    assign o_res.slow_zone     = r_res.slow_zone;
    assign o_res.axis_position = r_res.axis_position;

    // a homed tick leaves the position at zero
    a_home_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_smp.home_switch |=> r_state.position == '0)
        else $error("home tick did not zero the position");

    // the delivered flag is the stored flag it came with
    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_res.slow_zone == r_state.slow_flag)
        else $error("slow-zone output disagrees with stored flag");

    // drive magnitude never exceeds full speed
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.drive_command <= 8'sd100) &&
                        (o_res.drive_command >= -8'sd100))
        else $error("drive command out of range");

    // a waiting sample is not dropped while the result is stalled
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_smp))
        else $error("stalled sample lost");

    // after any tick the tracker is started
    a_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_state.started)
        else $error("tracker not started after a tick");

endmodule

/* tb/axis_drive_checker.sv */
module axis_drive_checker
    import hsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hsl_in_if                     tick_mon,
    hsl_out_if                    drive_mon,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [POS_W+1:0] POS_TOP    = {3'b000, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W+1:0] POS_BOTTOM = -POS_TOP - 1;
    localparam int                      PRINT_CAP  = 40;

    t_cfg    limits;
    t_state  axis;
    t_result drive_expect_q[$];
    int      fails;
    int      checked;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fails < PRINT_CAP) begin
            $display("%0t ns: result %0d %s: got %0d, expected %0d",
                     $time, checked, what, got, want);
        end
        fails++;
    endtask

    // Advance the axis by one tick and return the result it should produce.
    function automatic t_result advance_axis(input t_sample s);
        logic signed [COUNT_W-1:0] delta;
        logic signed [POS_W+1:0]   moved;
        logic signed [EXT_W:0]     pos_x;
        logic signed [EXT_W:0]     below;
        logic signed [EXT_W:0]     above;
        logic signed [EXT_W:0]     band_lo;
        logic signed [EXT_W:0]     band_hi;
        logic [SPEED_W-1:0]        speed;
        logic signed [DRIVE_W-1:0] mag;
        t_result                   r;

        if (s.home_switch) begin
            axis.position   = '0;
            axis.last_count = s.encoder_count;
            axis.started    = 1'b1;
        end else if (axis.started) begin
            delta = s.encoder_count - axis.last_count;
            moved = $signed(axis.position) - delta;
            if (moved > POS_TOP) begin
                axis.position = POS_TOP[POS_W-1:0];
            end else if (moved < POS_BOTTOM) begin
                axis.position = POS_BOTTOM[POS_W-1:0];
            end else begin
                axis.position = moved[POS_W-1:0];
            end
            axis.last_count = s.encoder_count;
        end else begin
            axis.last_count = s.encoder_count;
            axis.started    = 1'b1;
        end

        pos_x   = $signed(axis.position);
        below   = $signed(limits.slow_below);
        above   = $signed(limits.slow_above);
        band_lo = $signed(limits.fast_from);
        band_hi = $signed(limits.fast_to);
        if (pos_x <= below || pos_x >= above) begin
            axis.slow_flag = 1'b1;
        end else if (pos_x >= band_lo && pos_x <= band_hi) begin
            axis.slow_flag = 1'b0;
        end

        speed = axis.slow_flag ? limits.creep_speed : limits.cruise_speed;
        if (speed > SPEED_MAX) begin
            speed = SPEED_MAX;
        end
        mag = DRIVE_W'(speed);

        if (s.home_switch) begin
            r.drive_command = s.reverse_button ? -mag : '0;
        end else if (s.far_switch) begin
            r.drive_command = s.forward_button ? mag : '0;
        end else if (s.forward_button) begin
            r.drive_command = mag;
        end else if (s.reverse_button) begin
            r.drive_command = -mag;
        end else begin
            r.drive_command = '0;
        end
        r.slow_zone     = axis.slow_flag;
        r.axis_position = OUT_POS_W'($signed(axis.position));
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sample s;
        t_result want;
        if (!i_rst_n) begin
            limits.cruise_speed = RST_CRUISE_SPEED;
            limits.creep_speed  = RST_CREEP_SPEED;
            limits.slow_below   = RST_SLOW_BELOW;
            limits.slow_above   = RST_SLOW_ABOVE;
            limits.fast_from    = RST_FAST_FROM;
            limits.fast_to      = RST_FAST_TO;
            axis                = '0;
            drive_expect_q.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CRUISE_SPEED: limits.cruise_speed = i_cfg_data[SPEED_W-1:0];
                    CFG_CREEP_SPEED:  limits.creep_speed  = i_cfg_data[SPEED_W-1:0];
                    CFG_SLOW_BELOW:   limits.slow_below   = i_cfg_data[THR_W-1:0];
                    CFG_SLOW_ABOVE:   limits.slow_above   = i_cfg_data[THR_W-1:0];
                    CFG_FAST_FROM:    limits.fast_from    = i_cfg_data[THR_W-1:0];
                    CFG_FAST_TO:      limits.fast_to      = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (tick_mon.valid && tick_mon.ready) begin
                s.encoder_count  = tick_mon.encoder_count;
                s.home_switch    = tick_mon.home_switch;
                s.far_switch     = tick_mon.far_switch;
                s.forward_button = tick_mon.forward_button;
                s.reverse_button = tick_mon.reverse_button;
                drive_expect_q.push_back(advance_axis(s));
            end
            if (drive_mon.valid && drive_mon.ready) begin
                if (drive_expect_q.size() == 0) begin
                    report_mismatch("arrived with nothing pending, axis_position",
                                    longint'($signed(drive_mon.axis_position)), 0);
                end else begin
                    want = drive_expect_q.pop_front();
                    if (drive_mon.drive_command !== want.drive_command) begin
                        report_mismatch("drive_command",
                                        longint'($signed(drive_mon.drive_command)),
                                        longint'($signed(want.drive_command)));
                    end
                    if (drive_mon.slow_zone !== want.slow_zone) begin
                        report_mismatch("slow_zone", longint'(drive_mon.slow_zone),
                                        longint'(want.slow_zone));
                    end
                    if (drive_mon.axis_position !== want.axis_position) begin
                        report_mismatch("axis_position",
                                        longint'($signed(drive_mon.axis_position)),
                                        longint'($signed(want.axis_position)));
                    end
                end
                checked++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= drive_expect_q.size();
        o_checked    <= checked;
    end

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hsl_pkg::*;

    // The block registers the item and then the result.
    localparam int RESULT_LATENCY = 2;
    // Longest natural quiet stretch is a sender gap plus a receiver stall plus
    // a handful of register writes.
    localparam int WATCHDOG_LIMIT = 400;
    localparam int MAX_IDLE       = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_FAST_TO + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    localparam logic signed [THR_W-1:0] THR_MIN = 32'sh8000_0000;
    localparam logic signed [THR_W-1:0] THR_MAX = 32'sh7FFF_FFFF;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    hsl_in_if  tick_ch ();
    hsl_out_if drive_ch ();

    int chk_fails;
    int chk_pending;
    int chk_checked;

    // Stimulus bookkeeping: last encoder count sent and a rough position
    // estimate used only to steer the random walk toward the thresholds.
    logic [COUNT_W-1:0] enc_cnt;
    longint             walk_pos;
    int                 sent_items;
    bit                 no_idle;
    int                 quiet_cycles;

    homed_axis_speed_limiter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (tick_ch),
        .o_res      (drive_ch)
    );

    axis_drive_checker drive_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .tick_mon     (tick_ch),
        .drive_mon    (drive_ch),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked)
    );

    always #5 i_clk = ~i_clk;

    // Abort when neither channel moves for too long: a hung pipeline or a
    // result that never shows up.
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) || (drive_ch.valid && drive_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, chk_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: draw a stall per item, then hold ready until one is taken.
    initial begin
        int stall;
        drive_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                drive_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            drive_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!drive_ch.valid);
        end
    end

    // Offer one tick after a random gap and hold it until accepted. Valid
    // stays high into the next call when that call draws no gap.
    task automatic send_tick(input logic [COUNT_W-1:0] cnt, input logic home,
                             input logic far, input logic fwd, input logic rev);
        int                        gap;
        logic signed [COUNT_W-1:0] step_d;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid          <= 1'b1;
        tick_ch.encoder_count  <= cnt;
        tick_ch.home_switch    <= home;
        tick_ch.far_switch     <= far;
        tick_ch.forward_button <= fwd;
        tick_ch.reverse_button <= rev;
        do @(posedge i_clk); while (!tick_ch.ready);
        sent_items++;
        // Track the position the way the axis counts it: down for a rising count.
        step_d = cnt - enc_cnt;
        if (home) begin
            walk_pos = 0;
        end else begin
            walk_pos = walk_pos - step_d;
        end
        enc_cnt = cnt;
    endtask

    // Drop valid and wait until every expected result is in, then let the
    // pipeline settle before anything touches the registers.
    task automatic drain_block();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Load a full register set while idle. Speed writes carry random upper
    // bits, which the block must drop; spare indexes get junk to be ignored.
    task automatic load_settings(input logic [SPEED_W-1:0] nrm, input logic [SPEED_W-1:0] slw,
                                 input logic signed [THR_W-1:0] sb,
                                 input logic signed [THR_W-1:0] sa,
                                 input logic signed [THR_W-1:0] ff,
                                 input logic signed [THR_W-1:0] ft, input bit with_spare);
        logic [CFG_DATA_W-1:0] junk;
        drain_block();
        junk = $urandom;
        write_reg(CFG_CRUISE_SPEED, {junk[CFG_DATA_W-1:SPEED_W], nrm});
        junk = $urandom;
        write_reg(CFG_CREEP_SPEED, {junk[CFG_DATA_W-1:SPEED_W], slw});
        write_reg(CFG_SLOW_BELOW, sb);
        write_reg(CFG_SLOW_ABOVE, sa);
        write_reg(CFG_FAST_FROM, ff);
        write_reg(CFG_FAST_TO, ft);
        if (with_spare) begin
            write_reg(CFG_SPARE_LO, $urandom);
            write_reg(CFG_SPARE_HI, $urandom);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Random walk: segments of steady motion with random step sizes, steered
    // back when the estimate leaves [lo, hi]; a few ticks of raw noise, an
    // occasional home press and random far-switch and button states.
    task automatic run_walk(input int n_ticks, input longint lo, input longint hi,
                            input int max_step, input int home_permille);
        int                 seg_left;
        bit                 go_up;
        int                 step;
        logic [COUNT_W-1:0] next;
        logic               home;
        logic               far;
        seg_left = 0;
        go_up    = 1'b0;
        repeat (n_ticks) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 60);
                go_up    = 1'($urandom_range(0, 1));
                no_idle  = ($urandom_range(0, 4) == 0);
            end
            seg_left--;
            if (walk_pos < lo) begin
                go_up = 1'b1;
            end else if (walk_pos > hi) begin
                go_up = 1'b0;
            end
            step = $urandom_range(0, max_step);
            if ($urandom_range(0, 99) < 6) begin
                next = COUNT_W'($urandom);
            end else begin
                next = go_up ? enc_cnt - COUNT_W'(step) : enc_cnt + COUNT_W'(step);
            end
            home = ($urandom_range(0, 999) < home_permille);
            far  = ($urandom_range(0, 19) == 0);
            send_tick(next, home, far, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        tick_ch.valid          <= 1'b0;
        tick_ch.encoder_count  <= '0;
        tick_ch.home_switch    <= 1'b0;
        tick_ch.far_switch     <= 1'b0;
        tick_ch.forward_button <= 1'b0;
        tick_ch.reverse_button <= 1'b0;
        enc_cnt    = '0;
        walk_pos   = 0;
        sent_items = 0;
        no_idle    = 1'b0;

        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset settings (normal 100, slow 30, slow at 0).
        // Home on the very first tick: zero and start; forward is blocked.
        send_tick(16'h1234, 1'b1, 1'b0, 1'b1, 1'b0);
        send_tick(16'h1234, 1'b1, 1'b0, 1'b0, 1'b1);
        // Both switches: home wins, only reverse passes.
        send_tick(16'h1234, 1'b1, 1'b1, 1'b1, 1'b1);
        send_tick(16'h1234, 1'b1, 1'b1, 1'b1, 1'b0);
        // Far switch alone blocks reverse.
        send_tick(16'h1234, 1'b0, 1'b1, 1'b1, 1'b1);
        send_tick(16'h1234, 1'b0, 1'b1, 1'b0, 1'b1);
        // Both buttons, no switch: forward wins. Then count extremes and wrap.
        send_tick(16'h7FFF, 1'b0, 1'b0, 1'b1, 1'b1);
        send_tick(16'h8000, 1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(16'h0000, 1'b0, 1'b0, 1'b0, 1'b1);
        // Zero, then climb in half-turn steps into the clearing band.
        send_tick(16'h0000, 1'b1, 1'b0, 1'b0, 1'b0);
        repeat (13) begin
            send_tick(enc_cnt + 16'h8000, 1'b0, 1'b0, 1'b1, 1'b0);
        end

        // Speeds above the limit must clamp, in and out of the slow zone.
        load_settings(7'd127, 7'd101, RST_SLOW_BELOW, RST_SLOW_ABOVE, RST_FAST_FROM,
                      RST_FAST_TO, 1'b0);
        send_tick(enc_cnt, 1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(enc_cnt, 1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(enc_cnt, 1'b1, 1'b0, 1'b0, 1'b1);

        // Random phases. Reset-value thresholds first, spanning the full travel.
        load_settings(RST_CRUISE_SPEED, RST_CREEP_SPEED, RST_SLOW_BELOW, RST_SLOW_ABOVE,
                      RST_FAST_FROM, RST_FAST_TO, 1'b0);
        run_walk(250, 0, 2000000, 30000, 2);

        // Narrow zone around zero, speeds at both extremes.
        load_settings(7'd127, 7'd0, -50000, 50000, -20000, 20000, 1'b0);
        run_walk(250, -80000, 80000, 4000, 10);

        // Thresholds at the extremes of their range; spare indexes written.
        load_settings(7'd0, 7'd127, THR_MIN, THR_MAX, THR_MIN, THR_MAX, 1'b1);
        run_walk(200, -300000, 300000, 20000, 5);

        // Empty clearing band: once set, the flag never drops.
        load_settings(7'd55, 7'd101, -100000, 100000, 30000, -30000, 1'b0);
        run_walk(200, -150000, 150000, 8000, 5);

        // Random settings: thresholds near the travel, then anywhere at all.
        repeat (3) begin
            load_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                          $urandom_range(0, 300000) - 150000,
                          $urandom_range(0, 300000) - 150000,
                          $urandom_range(0, 300000) - 150000,
                          $urandom_range(0, 300000) - 150000, 1'b1);
            run_walk(100, -200000, 200000, 10000, 5);
        end
        load_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      $urandom, $urandom, $urandom, $urandom, 1'b0);
        run_walk(60, -200000, 200000, 32767, 5);

        drain_block();
        $display("Sent %0d ticks and checked %0d drive results across ten register sets,",
                 sent_items, chk_checked);
        $display("with switch and button priority, speed clamping, count wrap and hysteresis.");
        if (chk_fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", chk_fails);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
